### rtl/fvn_pkg.sv
package fvn_pkg;

    // Opcodes of an input item
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_INV_STEP     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERSISTENCE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OCTAVE_COUNT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_STRIDE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NORM_GAIN    = 3'd4;

    // Scaled coordinate (coord * inv_step) >> 16, Q.16
    localparam int SCALE_W = 48;

    // pi in Q2.30
    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    // Item handed from the front to the back
    typedef struct packed {
        logic                opcode;
        logic [11:0]         table_index;
        logic [15:0]         table_value;
        logic [SCALE_W-1:0]  sx;
        logic [SCALE_W-1:0]  sy;
    } t_item;

    // (1 - cos(pi*m/2^bits)) / 2 in Q1.16; evaluated at elaboration only
    function automatic logic [16:0] f_half_versine(input int unsigned m,
                                                   input int unsigned bits);
        logic [63:0] coef [6];
        logic [63:0] theta;
        logic [63:0] t2;
        logic [63:0] h;
        coef[0] = 64'd536870912;
        coef[1] = 64'd44739243;
        coef[2] = 64'd1491308;
        coef[3] = 64'd26631;
        coef[4] = 64'd296;
        coef[5] = 64'd2;
        theta = (PI_Q30 * 64'(m)) >> bits;
        t2    = (theta * theta) >> 30;
        h     = coef[5];
        for (int n = 4; n >= 0; n--) begin
            h = coef[n] - ((t2 * h) >> 30);
        end
        h = (t2 * h) >> 30;
        h = h >> 1;
        return 17'((h + 64'd8192) >> 14);
    endfunction

endpackage

### rtl/fvn_in_if.sv
interface fvn_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [11:0] table_index;
    logic [15:0] table_value;
    logic [31:0] x_coord;
    logic [31:0] y_coord;

    modport source (output valid, opcode, table_index, table_value, x_coord, y_coord,
                    input ready);
    modport sink   (input valid, opcode, table_index, table_value, x_coord, y_coord,
                    output ready);
endinterface

### rtl/fvn_out_if.sv
interface fvn_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] altitude;

    modport source (output valid, altitude, input ready);
    modport sink   (input valid, altitude, output ready);
endinterface

### rtl/fractal_value_noise_2d_core.sv
// Channel    Dir  Transfer when              Payload
// i_item     in   i_item.valid & ready       opcode, table_index, table_value, x/y_coord
// o_result   out  o_result.valid & ready     altitude
// i_cfg_*    in   i_cfg_we                   i_cfg_idx, i_cfg_data
//
// A load passes through the front register and the queue to the table write and gives no result.
// A query passes through the front register and the queue, then per octave through the address
// step, four reads of the lattice memory, three blends and one accumulation; the final
// gain multiply and the output register follow. A stalled result holds the back.
// Reset (synchronous, active low) clears control state; the lattice is not cleared.
module fractal_value_noise_2d_core #(
    parameter int TABLE_DEPTH    = 4096,
    parameter int MAX_OCTAVES    = 8,
    parameter int COS_TABLE_BITS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    fvn_in_if.sink                            i_item,
    fvn_out_if.source                         o_result,
    input  logic                              i_cfg_we,
    input  logic [fvn_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [fvn_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import fvn_pkg::*;

    logic [31:0]  r_inv_step;
    logic [15:0]  r_persistence;
    logic [3:0]   r_octave_count;
    logic [11:0]  r_row_stride;
    logic [16:0]  r_norm_gain;

    logic         fq_valid;
    logic         fq_ready;
    t_item        fq_item;
    logic         qb_valid;
    logic         qb_ready;
    t_item        qb_item;

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_step     <= 32'd65536;
            r_persistence  <= 16'd32768;
            r_octave_count <= 4'd4;
            r_row_stride   <= 12'd64;
            r_norm_gain    <= 17'd34953;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_INV_STEP:     r_inv_step     <= i_cfg_data;
                CFG_PERSISTENCE:  r_persistence  <= i_cfg_data[15:0];
                CFG_OCTAVE_COUNT: r_octave_count <= i_cfg_data[3:0];
                CFG_ROW_STRIDE:   r_row_stride   <= i_cfg_data[11:0];
                CFG_NORM_GAIN:    r_norm_gain    <= i_cfg_data[16:0];
                default: begin
                end
            endcase
        end
    end

    fvn_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .i_inv_step (r_inv_step),
        .o_q_valid  (fq_valid),
        .i_q_ready  (fq_ready),
        .o_q_item   (fq_item)
    );

    fvn_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (fq_valid),
        .o_push_ready (fq_ready),
        .i_push_item  (fq_item),
        .o_pop_valid  (qb_valid),
        .i_pop_ready  (qb_ready),
        .o_pop_item   (qb_item)
    );

    fvn_back #(
        .TABLE_DEPTH    (TABLE_DEPTH),
        .MAX_OCTAVES    (MAX_OCTAVES),
        .COS_TABLE_BITS (COS_TABLE_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_pop_valid    (qb_valid),
        .o_pop_ready    (qb_ready),
        .i_pop_item     (qb_item),
        .i_persistence  (r_persistence),
        .i_octave_count (r_octave_count),
        .i_row_stride   (r_row_stride),
        .i_norm_gain    (r_norm_gain),
        .o_result       (o_result)
    );

endmodule

### rtl/fvn_front.sv
module fvn_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    fvn_in_if.sink          i_item,
    input  logic [31:0]     i_inv_step,
    output logic            o_q_valid,
    input  logic            i_q_ready,
    output fvn_pkg::t_item  o_q_item
);
    import fvn_pkg::*;

    logic          r_valid;
    t_item         r_item;
    logic [63:0]   prod_x;
    logic [63:0]   prod_y;

    // Scale both coordinates by the reciprocal grid step
    assign prod_x = {32'd0, i_item.x_coord} * {32'd0, i_inv_step};
    assign prod_y = {32'd0, i_item.y_coord} * {32'd0, i_inv_step};

    assign i_item.ready = !r_valid || i_q_ready;
    assign o_q_valid    = r_valid;
    assign o_q_item     = r_item;

    // Hold one classified item until the queue takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_item.valid && i_item.ready) begin
            r_valid <= 1'b1;
        end else if (i_q_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_item.opcode      <= i_item.opcode;
            r_item.table_index <= i_item.table_index;
            r_item.table_value <= i_item.table_value;
            r_item.sx          <= (i_item.opcode == OP_QUERY) ? prod_x[63:16] : '0;
            r_item.sy          <= (i_item.opcode == OP_QUERY) ? prod_y[63:16] : '0;
        end
    end

endmodule

### rtl/fvn_queue.sv
module fvn_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    input  fvn_pkg::t_item  i_push_item,
    output logic            o_pop_valid,
    input  logic            i_pop_ready,
    output fvn_pkg::t_item  o_pop_item
);
    import fvn_pkg::*;

    t_item       r_slot [2];
    logic        r_wr;
    logic        r_rd;
    logic [1:0]  r_cnt;
    logic        push;
    logic        pop;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_pop_valid  = (r_cnt != 2'd0);
    assign o_pop_item   = r_slot[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= !r_wr;
            end
            if (pop) begin
                r_rd <= !r_rd;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr] <= i_push_item;
        end
    end

endmodule

### rtl/fvn_back.sv
module fvn_back #(
    parameter int TABLE_DEPTH    = 4096,
    parameter int MAX_OCTAVES    = 8,
    parameter int COS_TABLE_BITS = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_pop_valid,
    output logic            o_pop_ready,
    input  fvn_pkg::t_item  i_pop_item,
    input  logic [15:0]     i_persistence,
    input  logic [3:0]      i_octave_count,
    input  logic [11:0]     i_row_stride,
    input  logic [16:0]     i_norm_gain,
    fvn_out_if.source       o_result
);
    import fvn_pkg::*;

    localparam int AW       = $clog2(TABLE_DEPTH);
    localparam int IW       = AW + 14;
    localparam int JW       = $clog2(MAX_OCTAVES + 1);
    localparam int UX_W     = SCALE_W + MAX_OCTAVES - 1;
    localparam int CX_W     = UX_W - 16;
    localparam int ZW       = 34 + $clog2(MAX_OCTAVES);
    localparam int PW       = ZW + 17;
    localparam int COS_SIZE = 1 << COS_TABLE_BITS;

    typedef logic [16:0] t_cos_lut [COS_SIZE];

    function automatic t_cos_lut f_build_cos();
        t_cos_lut lut;
        for (int i = 0; i < COS_SIZE; i++) begin
            if (i <= COS_SIZE / 2) begin
                lut[i] = f_half_versine(i, COS_TABLE_BITS);
            end else begin
                lut[i] = 17'd65536 - f_half_versine(COS_SIZE - i, COS_TABLE_BITS);
            end
        end
        return lut;
    endfunction

    localparam t_cos_lut COS_LUT = f_build_cos();

    function automatic logic [15:0] f_blend(input logic [15:0] a, input logic [15:0] b,
                                            input logic [16:0] k);
        logic [33:0] s;
        s = 34'(a) * 34'(17'd65536 - k) + 34'(b) * 34'(k) + 34'd32768;
        return 16'(s >> 16);
    endfunction

    typedef enum logic [3:0] {
        S_IDLE, S_ADDR, S_READ, S_BLEND0, S_BLEND1, S_BLEND2, S_ACC, S_FIN, S_OUT
    } t_state;

    t_state              r_state;
    logic [SCALE_W-1:0]  r_sx;
    logic [SCALE_W-1:0]  r_sy;
    logic [JW-1:0]       r_j;
    logic [JW-1:0]       r_n;
    logic [16:0]         r_p;
    logic [ZW-1:0]       r_z;
    logic [16:0]         r_kx;
    logic [16:0]         r_ky;
    logic [AW-1:0]       r_addr [4];
    logic                r_oob [4];
    logic [15:0]         r_corner [4];
    logic [2:0]          r_rcnt;
    logic [15:0]         r_r0;
    logic [15:0]         r_r1;
    logic [15:0]         r_noise;
    logic [PW-1:0]       r_prod;
    logic                r_out_valid;
    logic [15:0]         r_altitude;
    logic [15:0]         r_lattice [TABLE_DEPTH];
    logic [15:0]         r_rd_data;

    logic [UX_W-1:0]     ux;
    logic [UX_W-1:0]     uy;
    logic [CX_W-1:0]     cx;
    logic [CX_W-1:0]     cy;
    logic                oob_x;
    logic                oob_y;
    logic [IW-1:0]       base0;
    logic [IW-1:0]       base1;
    logic [IW-1:0]       idx [4];
    logic [JW-1:0]       oct_n;
    logic                load_we;
    logic [AW-1:0]       rd_addr;
    logic [1:0]          cap_idx;
    logic [PW:0]         rounded;
    logic                out_free;

    // Corner addresses and blend weights of the current octave
    always_comb begin
        ux     = UX_W'(r_sx) << r_j;
        uy     = UX_W'(r_sy) << r_j;
        cx     = ux[UX_W-1:16];
        cy     = uy[UX_W-1:16];
        oob_x  = (i_row_stride != 12'd0) && (cx >= CX_W'(TABLE_DEPTH));
        oob_y  = (cy >= CX_W'(TABLE_DEPTH));
        base0  = IW'(cx[AW-1:0]) * IW'(i_row_stride) + IW'(cy[AW-1:0]);
        base1  = base0 + IW'(i_row_stride);
        idx[0] = base0;
        idx[1] = base1;
        idx[2] = base0 + IW'(1);
        idx[3] = base1 + IW'(1);
    end

    // Clamp the octave count
    assign oct_n = (int'(i_octave_count) > MAX_OCTAVES) ? JW'(MAX_OCTAVES)
                                                       : JW'(i_octave_count);

    assign o_pop_ready = (r_state == S_IDLE);
    assign load_we     = (r_state == S_IDLE) && i_pop_valid
                         && (i_pop_item.opcode == OP_LOAD)
                         && (int'(i_pop_item.table_index) < TABLE_DEPTH);
    assign rd_addr     = r_addr[r_rcnt[1:0]];
    assign cap_idx     = 2'(r_rcnt - 3'd1);
    assign rounded     = (PW+1)'(r_prod) + (PW+1)'(64'h8000_0000);
    assign out_free    = !r_out_valid || o_result.ready;

    assign o_result.valid    = r_out_valid;
    assign o_result.altitude = r_altitude;

    // Lattice table: one write and one read per cycle
    always_ff @(posedge i_clk) begin
        if (load_we) begin
            r_lattice[AW'(i_pop_item.table_index)] <= i_pop_item.table_value;
        end
        r_rd_data <= r_lattice[rd_addr];
    end

    // Octave sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_rcnt      <= 3'd0;
            r_j         <= '0;
            r_n         <= '0;
            r_p         <= 17'd65536;
        end else begin
            if (o_result.ready && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_pop_valid && i_pop_item.opcode == OP_QUERY) begin
                        r_sx    <= i_pop_item.sx;
                        r_sy    <= i_pop_item.sy;
                        r_j     <= '0;
                        r_n     <= oct_n;
                        r_p     <= 17'd65536;
                        r_z     <= '0;
                        r_state <= (oct_n == '0) ? S_FIN : S_ADDR;
                    end
                end
                S_ADDR: begin
                    r_kx <= COS_LUT[ux[15 -: COS_TABLE_BITS]];
                    r_ky <= COS_LUT[uy[15 -: COS_TABLE_BITS]];
                    for (int i = 0; i < 4; i++) begin
                        r_addr[i] <= idx[i][AW-1:0];
                        r_oob[i]  <= oob_x || oob_y || (idx[i] >= IW'(TABLE_DEPTH));
                    end
                    r_rcnt  <= 3'd0;
                    r_state <= S_READ;
                end
                S_READ: begin
                    if (r_rcnt != 3'd0) begin
                        r_corner[cap_idx] <= r_oob[cap_idx] ? 16'd0 : r_rd_data;
                    end
                    if (r_rcnt == 3'd4) begin
                        r_rcnt  <= 3'd0;
                        r_state <= S_BLEND0;
                    end else begin
                        r_rcnt <= r_rcnt + 3'd1;
                    end
                end
                S_BLEND0: begin
                    r_r0    <= f_blend(r_corner[0], r_corner[1], r_kx);
                    r_state <= S_BLEND1;
                end
                S_BLEND1: begin
                    r_r1    <= f_blend(r_corner[2], r_corner[3], r_kx);
                    r_state <= S_BLEND2;
                end
                S_BLEND2: begin
                    r_noise <= f_blend(r_r0, r_r1, r_ky);
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_z   <= r_z + ZW'(34'(r_p) * 34'(r_noise));
                    r_p   <= 17'((34'(r_p) * 34'(i_persistence) + 34'd32768) >> 16);
                    r_j   <= r_j + JW'(1);
                    r_state <= (r_j + JW'(1) == r_n) ? S_FIN : S_ADDR;
                end
                S_FIN: begin
                    r_prod  <= PW'(r_z) * PW'(i_norm_gain);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_altitude  <= ((rounded >> 32) > (PW+1)'(65535)) ? 16'hFFFF
                                                                         : rounded[47:32];
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p <= 17'd65536)
        else $error("octave weight above 1.0");

    a_read_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rcnt <= 3'd4)
        else $error("corner read count out of range");

    a_octave_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_j <= r_n))
        else $error("octave index beyond octave count");

    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_pop_valid && i_pop_item.opcode == OP_LOAD)
        |=> (r_state == S_IDLE))
        else $error("load item started a query");
`endif

endmodule

### dv/fvn_altitude_checker.sv
`timescale 1ns / 1ps

module fvn_altitude_checker #(
    parameter int TABLE_DEPTH    = 4096,
    parameter int MAX_OCTAVES    = 8,
    parameter int COS_TABLE_BITS = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    fvn_in_if                              i_item,
    fvn_out_if                             i_result,
    input  logic                           i_cfg_we,
    input  logic [fvn_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [fvn_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending
);
    import fvn_pkg::*;

    localparam int COS_SIZE = 1 << COS_TABLE_BITS;

    logic [15:0] lattice_copy [TABLE_DEPTH];
    logic [16:0] blend_weight [COS_SIZE];
    logic [31:0] inv_step_r;
    logic [15:0] persistence_r;
    logic [3:0]  octaves_r;
    logic [11:0] stride_r;
    logic [16:0] gain_r;
    logic [15:0] altitude_q [$];

    // (1 - cos(pi*m/2^bits)) / 2 in Q1.16, built from a degree-12 series in Q2.30
    function automatic logic [16:0] half_versine_q16(input int unsigned m);
        logic [63:0] coef [6];
        logic [63:0] theta;
        logic [63:0] t2;
        logic [63:0] acc;
        coef[0] = 64'd536870912;
        coef[1] = 64'd44739243;
        coef[2] = 64'd1491308;
        coef[3] = 64'd26631;
        coef[4] = 64'd296;
        coef[5] = 64'd2;
        theta = (64'd3373259426 * 64'(m)) >> COS_TABLE_BITS;
        t2    = (theta * theta) >> 30;
        acc   = coef[5];
        for (int n = 4; n >= 0; n--) begin
            acc = coef[n] - ((t2 * acc) >> 30);
        end
        acc = ((t2 * acc) >> 30) >> 1;
        return 17'((acc + 64'd8192) >> 14);
    endfunction

    initial begin
        for (int i = 0; i < COS_SIZE; i++) begin
            if (i <= COS_SIZE / 2) begin
                blend_weight[i] = half_versine_q16(i);
            end else begin
                blend_weight[i] = 17'd65536 - half_versine_q16(COS_SIZE - i);
            end
        end
    end

    // Out-of-range corners read as zero
    function automatic logic [63:0] corner(input logic [63:0] idx);
        return (idx < 64'(TABLE_DEPTH)) ? 64'(lattice_copy[idx]) : 64'd0;
    endfunction

    function automatic logic [63:0] mix(input logic [63:0] a, input logic [63:0] b,
                                        input logic [16:0] k);
        return (a * (64'd65536 - 64'(k)) + b * 64'(k) + 64'd32768) >> 16;
    endfunction

    function automatic logic [63:0] octave_value(input logic [31:0] x, input logic [31:0] y,
                                                 input int j);
        logic [63:0] ux, uy, cx, cy, row0, row1, r0, r1;
        logic [16:0] kx, ky;
        ux   = ((64'(x) * 64'(inv_step_r)) >> 16) << j;
        uy   = ((64'(y) * 64'(inv_step_r)) >> 16) << j;
        cx   = ux >> 16;
        cy   = uy >> 16;
        kx   = blend_weight[ux[15:0] >> (16 - COS_TABLE_BITS)];
        ky   = blend_weight[uy[15:0] >> (16 - COS_TABLE_BITS)];
        row0 = cx * 64'(stride_r) + cy;
        row1 = (cx + 64'd1) * 64'(stride_r) + cy;
        r0   = mix(corner(row0), corner(row1), kx);
        r1   = mix(corner(row0 + 64'd1), corner(row1 + 64'd1), kx);
        return mix(r0, r1, ky);
    endfunction

    function automatic logic [15:0] altitude_of(input logic [31:0] x, input logic [31:0] y);
        logic [63:0] weight, sum, scaled;
        int          n;
        weight = 64'd65536;
        sum    = 64'd0;
        n      = (octaves_r > MAX_OCTAVES) ? MAX_OCTAVES : int'(octaves_r);
        for (int j = 0; j < n; j++) begin
            sum    = sum + weight * octave_value(x, y, j);
            weight = (weight * 64'(persistence_r) + 64'd32768) >> 16;
        end
        scaled = (sum * 64'(gain_r) + 64'h8000_0000) >> 32;
        return (scaled > 64'd65535) ? 16'hFFFF : scaled[15:0];
    endfunction

    assign o_pending = altitude_q.size();

    initial o_fail_count = 0;

    // Track registers and loads, predict on each query transfer, compare on each result transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            inv_step_r    <= 32'd65536;
            persistence_r <= 16'd32768;
            octaves_r     <= 4'd4;
            stride_r      <= 12'd64;
            gain_r        <= 17'd34953;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_INV_STEP:     inv_step_r    <= i_cfg_data;
                    CFG_PERSISTENCE:  persistence_r <= i_cfg_data[15:0];
                    CFG_OCTAVE_COUNT: octaves_r     <= i_cfg_data[3:0];
                    CFG_ROW_STRIDE:   stride_r      <= i_cfg_data[11:0];
                    CFG_NORM_GAIN:    gain_r        <= i_cfg_data[16:0];
                    default: ;
                endcase
            end
            if (i_item.valid && i_item.ready) begin
                if (i_item.opcode == OP_LOAD) begin
                    if (int'(i_item.table_index) < TABLE_DEPTH) begin
                        lattice_copy[i_item.table_index] = i_item.table_value;
                    end
                end else begin
                    altitude_q.push_back(altitude_of(i_item.x_coord, i_item.y_coord));
                end
            end
            if (i_result.valid && i_result.ready) begin
                if (altitude_q.size() == 0) begin
                    $error("altitude: expected none, actual %0d", i_result.altitude);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    if (i_result.altitude !== altitude_q[0]) begin
                        $error("altitude: expected %0d, actual %0d", altitude_q[0],
                               i_result.altitude);
                        o_fail_count = o_fail_count + 1;
                    end
                    void'(altitude_q.pop_front());
                end
            end
        end
    end

endmodule

### dv/tb_fractal_value_noise_2d_core.sv
`timescale 1ns / 1ps

module tb_fractal_value_noise_2d_core;
    import fvn_pkg::*;

    localparam int TABLE_DEPTH = 4096;
    localparam int SETTLE      = 120;
    localparam int LIMIT       = 4000000;
    localparam int PHASE_ITEMS = 145;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    int                    fail_count;
    int                    pending;
    logic                  in_fire;
    bit                    calm;
    int                    stall_left;

    fvn_in_if  in_ch ();
    fvn_out_if out_ch ();

    fractal_value_noise_2d_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (in_ch),
        .o_result   (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    fvn_altitude_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (in_ch),
        .i_result     (out_ch),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Flag an input transfer, read back after the edge
    always @(posedge i_clk) begin
        in_fire <= in_ch.valid && in_ch.ready;
    end

    initial begin
        in_ch.valid       = 1'b0;
        in_ch.opcode      = OP_LOAD;
        in_ch.table_index = '0;
        in_ch.table_value = '0;
        in_ch.x_coord     = '0;
        in_ch.y_coord     = '0;
        out_ch.ready      = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = '0;
        i_cfg_data        = '0;
        i_rst_n           = 1'b0;
        calm              = 1'b0;
        stall_left        = 0;
    end

    // Receiver back-pressure: mostly ready, with short stalls and now and then a long one
    initial begin
        forever begin
            @(negedge i_clk);
            if (calm) begin
                out_ch.ready <= 1'b1;
            end else if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left = stall_left - 1;
            end else begin
                case ($urandom_range(0, 99)) inside
                    [0:19]:  stall_left = $urandom_range(1, 3);
                    [20:22]: stall_left = $urandom_range(20, 60);
                    default: stall_left = 0;
                endcase
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        repeat (LIMIT) @(posedge i_clk);
        $display("status: fail");
        $finish;
    end

    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Mostly narrow coordinates of 4 to 24 bits; some span the full 32-bit range
    function automatic logic [31:0] pick_coord();
        int w;
        if ($urandom_range(0, 99) < 15) return $urandom;
        w = $urandom_range(4, 24);
        return $urandom & ((32'd1 << w) - 1);
    endfunction

    task automatic push_item(input logic op, input logic [11:0] idx, input logic [15:0] val,
                             input logic [31:0] x, input logic [31:0] y);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_ch.valid       <= 1'b1;
        in_ch.opcode      <= op;
        in_ch.table_index <= idx;
        in_ch.table_value <= val;
        in_ch.x_coord     <= x;
        in_ch.y_coord     <= y;
        do begin
            @(posedge i_clk);
            #1;
        end while (!in_fire);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Hold until every altitude is back, then let a trailing load finish
    task automatic drain();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [31:0] inv, input logic [31:0] pers,
                              input logic [31:0] oct, input logic [31:0] stride,
                              input logic [31:0] gain);
        drain();
        cfg_write(CFG_INV_STEP, inv);
        cfg_write(CFG_PERSISTENCE, pers);
        cfg_write(CFG_OCTAVE_COUNT, oct);
        cfg_write(CFG_ROW_STRIDE, stride);
        cfg_write(CFG_NORM_GAIN, gain);
    endtask

    task automatic random_items(input int count);
        for (int n = 0; n < count; n++) begin
            if (n == 20 && $urandom_range(0, 1) == 0) begin
                @(negedge i_clk);
                in_ch.valid <= 1'b0;
                while (pending != 0) @(posedge i_clk);
            end
            if ($urandom_range(0, 99) < 30) begin
                push_item(OP_LOAD, 12'($urandom), 16'($urandom), $urandom, $urandom);
            end else begin
                push_item(OP_QUERY, 12'($urandom), 16'($urandom), pick_coord(), pick_coord());
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Fill the whole lattice so no query reads an unwritten entry
        calm = 1'b1;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            push_item(OP_LOAD, 12'(i), 16'($urandom), $urandom, $urandom);
        end
        calm = 1'b0;

        // Directed: value extremes, coordinate extremes, fraction edges
        set_config(32'd65536, 32'd32768, 32'd4, 32'd64, 32'd34953);
        push_item(OP_LOAD, 12'd0, 16'd0, 32'd0, 32'd0);
        push_item(OP_LOAD, 12'd4095, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_item(OP_LOAD, 12'd65, 16'hFFFF, 32'd0, 32'd0);
        push_item(OP_QUERY, 12'd0, 16'd0, 32'd0, 32'd0);
        push_item(OP_QUERY, 12'hFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_item(OP_QUERY, 12'd0, 16'd0, 32'h0000_FFFF, 32'h0000_FFFF);
        push_item(OP_QUERY, 12'd0, 16'd0, 32'h0000_8000, 32'h0000_8000);
        push_item(OP_QUERY, 12'd0, 16'd0, 32'h0001_0000, 32'd0);
        push_item(OP_QUERY, 12'd0, 16'd0, 32'h003F_FFFF, 32'h003F_FFFF);
        push_item(OP_QUERY, 12'd0, 16'd0, 32'hFFFF_FFFF, 32'd0);
        push_item(OP_QUERY, 12'd0, 16'd0, 32'd0, 32'hFFFF_FFFF);
        push_item(OP_QUERY, 12'd0, 16'd0, 32'h0000_7F00, 32'h0000_0100);
        random_items(PHASE_ITEMS);

        // Lowest nonzero step, octave count and stride; zero persistence and gain
        set_config(32'd1, 32'd0, 32'd1, 32'd1, 32'd0);
        random_items(PHASE_ITEMS);

        // Highest step, persistence and stride; the maximum octave count; gain of 65536
        set_config(32'hFFFF_FFFF, 32'd65535, 32'd8, 32'd4095, 32'd65536);
        push_item(OP_QUERY, 12'd0, 16'd0, 32'd0, 32'd0);
        push_item(OP_QUERY, 12'd0, 16'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        random_items(PHASE_ITEMS);

        // Zero step and no octaves, then two octaves; zero stride and gain above unity in both
        set_config(32'd0, 32'd40000, 32'd0, 32'd0, 32'h1FFFF);
        random_items(40);
        set_config(32'd65536, 32'd40000, 32'd2, 32'd0, 32'h1FFFF);
        random_items(PHASE_ITEMS);

        // Octave count beyond the maximum is clamped
        set_config(32'd32768, 32'd45875, 32'd15, 32'd64, 32'd65536);
        random_items(PHASE_ITEMS);

        set_config(32'd131072, 32'd20000, 32'd3, 32'd32, 32'd90000);
        calm = 1'b1;
        random_items(60);
        calm = 1'b0;
        random_items(PHASE_ITEMS - 60);

        set_config($urandom, $urandom_range(0, 65535), $urandom_range(1, 8),
                   $urandom_range(1, 4095), $urandom_range(0, 65536));
        random_items(PHASE_ITEMS);

        set_config(32'd16384, 32'd32768, 32'd6, 32'd100, 32'd65536);
        random_items(PHASE_ITEMS);

        drain();
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
